>>> rtl/prcp_pkg.sv
// ----------------------------------------------------------------------------
// prcp_pkg
// Shared types and constants of the polar radar to Cartesian points block.
// ----------------------------------------------------------------------------
`default_nettype none

package prcp_pkg;

  localparam int MAX_RANGE_BINS_DEF = 4096;
  localparam int PHASE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_FRAC  = 30;
  localparam int STEP_W       = 5;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  localparam int COORD_W = 37;
  localparam logic [COORD_W-1:0] COORD_LIMIT = 37'd68702695425;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] RANGE_STEP_RST = 24'd1055;
  localparam logic [15:0] ANGLE_STEP_RST = 16'd164;
  localparam logic [12:0] BINS_RST       = 13'd3768;
  localparam logic [7:0]  THRESHOLD_RST  = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_STEP = 2'd0,
    CFG_ANGLE_STEP = 2'd1,
    CFG_BINS       = 2'd2,
    CFG_THRESHOLD  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_ROTATE,
    ST_TRIG,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_SUM,
    ST_EMIT
  } prcp_state_e;

  typedef struct packed {
    logic              accept;
    logic              range_en;
    logic              cordic_load;
    logic              cordic_step;
    logic [STEP_W-1:0] step;
    logic              trig_load;
    logic              mul_hi;
    logic              mul_lo;
    logic              sum;
    logic              axis;
    logic              emit;
  } prcp_cmd_t;

  typedef struct packed {
    logic hit;
    logic trig_cached;
    logic out_free;
  } prcp_sts_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input logic [STEP_W-1:0] i);
    case (i)
      5'd0:    atan_turn = 32'sd536870912;
      5'd1:    atan_turn = 32'sd316933406;
      5'd2:    atan_turn = 32'sd167458907;
      5'd3:    atan_turn = 32'sd85004756;
      5'd4:    atan_turn = 32'sd42667331;
      5'd5:    atan_turn = 32'sd21354465;
      5'd6:    atan_turn = 32'sd10679838;
      5'd7:    atan_turn = 32'sd5340245;
      5'd8:    atan_turn = 32'sd2670163;
      5'd9:    atan_turn = 32'sd1335087;
      5'd10:   atan_turn = 32'sd667544;
      5'd11:   atan_turn = 32'sd333772;
      5'd12:   atan_turn = 32'sd166886;
      5'd13:   atan_turn = 32'sd83443;
      5'd14:   atan_turn = 32'sd41722;
      5'd15:   atan_turn = 32'sd20861;
      5'd16:   atan_turn = 32'sd10430;
      5'd17:   atan_turn = 32'sd5215;
      5'd18:   atan_turn = 32'sd2608;
      5'd19:   atan_turn = 32'sd1304;
      5'd20:   atan_turn = 32'sd652;
      5'd21:   atan_turn = 32'sd326;
      5'd22:   atan_turn = 32'sd163;
      5'd23:   atan_turn = 32'sd81;
      5'd24:   atan_turn = 32'sd41;
      5'd25:   atan_turn = 32'sd20;
      5'd26:   atan_turn = 32'sd10;
      5'd27:   atan_turn = 32'sd5;
      default: atan_turn = 32'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/prcp_in_if.sv
// ----------------------------------------------------------------------------
// prcp_in_if
// Sample channel: valid/ready handshake with intensity and frame start.
// ----------------------------------------------------------------------------
`default_nettype none

interface prcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_intensity;
  logic       frame_start;

  modport source (output valid, output sample_intensity, output frame_start, input ready);
  modport sink (input valid, input sample_intensity, input frame_start, output ready);
endinterface

`default_nettype wire

>>> rtl/prcp_out_if.sv
// ----------------------------------------------------------------------------
// prcp_out_if
// Point channel: valid/ready handshake with x, y and intensity.
// ----------------------------------------------------------------------------
`default_nettype none

interface prcp_out_if;
  logic               valid;
  logic               ready;
  logic signed [36:0] point_x;
  logic signed [36:0] point_y;
  logic [7:0]         point_intensity;

  modport source (output valid, output point_x, output point_y, output point_intensity,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_intensity,
                output ready);
endinterface

`default_nettype wire

>>> rtl/prcp_ctrl.sv
// ----------------------------------------------------------------------------
// prcp_ctrl
// Sequencer: accepts items, runs the CORDIC loop and the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module prcp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire prcp_pkg::prcp_sts_t sts_i,
  output prcp_pkg::prcp_cmd_t      cmd_o
);
  import prcp_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  prcp_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    axis_d     = axis_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.step = step_q;
    cmd_o.axis = axis_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.hit) begin
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd_o.range_en = 1'b1;
        axis_d         = 1'b0;
        if (sts_i.trig_cached) begin
          state_d = ST_MUL_HI;
        end else begin
          cmd_o.cordic_load = 1'b1;
          step_d            = '0;
          state_d           = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        cmd_o.cordic_step = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_TRIG;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_TRIG: begin
        cmd_o.trig_load = 1'b1;
        state_d         = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        if (axis_q) begin
          state_d = ST_EMIT;
        end else begin
          axis_d  = 1'b1;
          state_d = ST_MUL_HI;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/prcp_dp.sv
// ----------------------------------------------------------------------------
// prcp_dp
// Datapath: config, bin and row counters, CORDIC, trig cache, scaling, output.
// ----------------------------------------------------------------------------
`default_nettype none

module prcp_dp #(
  parameter int MAX_RANGE_BINS = prcp_pkg::MAX_RANGE_BINS_DEF,
  parameter int PHASE_BITS     = prcp_pkg::PHASE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = prcp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [prcp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [prcp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic [7:0]                            sample_intensity_i,
  input  wire logic                                  frame_start_i,
  input  wire prcp_pkg::prcp_cmd_t                   cmd_i,
  output prcp_pkg::prcp_sts_t                        sts_o,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic signed [prcp_pkg::COORD_W-1:0]        point_x_o,
  output logic signed [prcp_pkg::COORD_W-1:0]        point_y_o,
  output logic [7:0]                                 point_intensity_o
);
  import prcp_pkg::*;

  localparam int BIN_W = $clog2(MAX_RANGE_BINS);
  localparam int RNG_W = BIN_W + 24;
  localparam int RH_W  = RNG_W - 16;
  localparam int MA_W  = (RH_W > 16) ? RH_W : 16;
  localparam int TM_W  = TRIG_FRAC_BITS + 2;
  localparam int TG_W  = TRIG_FRAC_BITS + 3;
  localparam int P_W   = MA_W + TM_W;
  localparam int CW    = 33;
  localparam int SH    = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam logic [31:0] ANG_RST32 = 32'(ANGLE_STEP_RST);
  localparam logic [31:0] MAX32     = 32'(MAX_RANGE_BINS);

  // config
  logic [23:0] range_step_q;
  logic [15:0] angle_step_q;
  logic [12:0] bins_q;
  logic [7:0]  thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_step_q <= RANGE_STEP_RST;
      angle_step_q <= ANGLE_STEP_RST;
      bins_q       <= BINS_RST;
      thr_q        <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_RANGE_STEP: range_step_q <= cfg_data_i;
        CFG_ANGLE_STEP: angle_step_q <= cfg_data_i[15:0];
        CFG_BINS:       bins_q       <= cfg_data_i[12:0];
        CFG_THRESHOLD:  thr_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // bin and row counters
  logic [BIN_W-1:0]      bin_q, bin_d, bin_eff;
  logic [PHASE_BITS-1:0] phase_q, phase_d, ph_eff, ang_pb;
  logic [31:0]           ang32, bins32, row_len32, bin_inc32;

  always_comb begin
    ang32     = 32'(angle_step_q);
    ang_pb    = ang32[PHASE_BITS-1:0];
    bin_eff   = frame_start_i ? '0 : bin_q;
    ph_eff    = frame_start_i ? ang_pb : phase_q;
    bins32    = 32'(bins_q);
    if (bins_q == '0) begin
      row_len32 = 32'd1;
    end else if (bins32 > MAX32) begin
      row_len32 = MAX32;
    end else begin
      row_len32 = bins32;
    end
    bin_inc32 = 32'(bin_eff) + 32'd1;
    if (bin_inc32 >= row_len32) begin
      bin_d   = '0;
      phase_d = ph_eff + ang_pb;
    end else begin
      bin_d   = bin_inc32[BIN_W-1:0];
      phase_d = ph_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q   <= '0;
      phase_q <= ANG_RST32[PHASE_BITS-1:0];
    end else if (cmd_i.accept) begin
      bin_q   <= bin_d;
      phase_q <= phase_d;
    end
  end

  logic [BIN_W-1:0]      bin_use_q;
  logic [PHASE_BITS-1:0] phase_use_q;
  logic [7:0]            inten_q;
  logic [RNG_W-1:0]      range_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bin_use_q   <= bin_eff;
      phase_use_q <= ph_eff;
      inten_q     <= sample_intensity_i;
    end
    if (cmd_i.range_en) begin
      range_q <= RNG_W'(bin_use_q) * RNG_W'(range_step_q);
    end
  end

  // cordic
  logic signed [CW-1:0] cx_q, cy_q, shx, shy;
  logic signed [31:0]   cz_q, atan_i;
  logic [1:0]           quad_q;
  logic [31:0]          p32;

  always_comb begin
    p32    = {phase_use_q, {(32 - PHASE_BITS){1'b0}}};
    shx    = cx_q >>> cmd_i.step;
    shy    = cy_q >>> cmd_i.step;
    atan_i = atan_turn(cmd_i.step);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_load) begin
      cx_q   <= CORDIC_START;
      cy_q   <= '0;
      cz_q   <= $signed({2'b00, p32[29:0]});
      quad_q <= p32[31:30];
    end else if (cmd_i.cordic_step) begin
      if (!cz_q[31]) begin
        cx_q <= cx_q - shy;
        cy_q <= cy_q + shx;
        cz_q <= cz_q - atan_i;
      end else begin
        cx_q <= cx_q + shy;
        cy_q <= cy_q - shx;
        cz_q <= cz_q + atan_i;
      end
    end
  end

  function automatic logic signed [TG_W-1:0] rnd(input logic signed [CW-1:0] v);
    logic [CW-1:0] mag;
    logic [CW-1:0] r;
    mag = v[CW-1] ? CW'(-v) : CW'(v);
    r   = (mag + (CW'(1) << (SH - 1))) >> SH;
    rnd = v[CW-1] ? -$signed(TG_W'(r)) : $signed(TG_W'(r));
  endfunction

  // trig cache for the last phase seen
  logic signed [TG_W-1:0] c_q, s_q, rx, ry;
  logic [PHASE_BITS-1:0]  tag_q;
  logic                   trig_valid_q;

  always_comb begin
    rx = rnd(cx_q);
    ry = rnd(cy_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.trig_load) begin
      tag_q <= phase_use_q;
      case (quad_q)
        2'd0: begin
          c_q <= rx;
          s_q <= ry;
        end
        2'd1: begin
          c_q <= -ry;
          s_q <= rx;
        end
        2'd2: begin
          c_q <= -rx;
          s_q <= -ry;
        end
        default: begin
          c_q <= ry;
          s_q <= -rx;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_valid_q <= 1'b0;
    end else if (cmd_i.trig_load) begin
      trig_valid_q <= 1'b1;
    end
  end

  // scaling: shared multiplier, high and low range halves
  logic signed [TG_W-1:0] tsel;
  logic [TM_W-1:0]        tmag;
  logic [MA_W-1:0]        mul_a;
  logic [P_W-1:0]         prod, hi_q, lo_q;
  logic                   neg_q;

  always_comb begin
    tsel  = cmd_i.axis ? s_q : c_q;
    tmag  = tsel[TG_W-1] ? TM_W'(-tsel) : TM_W'(tsel);
    mul_a = cmd_i.mul_hi ? MA_W'(range_q[RNG_W-1:16]) : MA_W'(range_q[15:0]);
    prod  = P_W'(mul_a) * P_W'(tmag);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_hi) begin
      hi_q  <= prod;
      neg_q <= tsel[TG_W-1];
    end
    if (cmd_i.mul_lo) begin
      lo_q <= prod;
    end
  end

  logic [63:0]              hi64, sum64, mag64;
  logic [COORD_W-1:0]       mag_c;
  logic signed [COORD_W-1:0] coord;
  logic signed [COORD_W-1:0] x_res_q, y_res_q;

  always_comb begin
    hi64  = 64'(hi_q);
    sum64 = (hi64 << 16) + 64'(lo_q) + (64'd1 << (TRIG_FRAC_BITS - 1));
    mag64 = sum64 >> TRIG_FRAC_BITS;
    if ((hi64 >= (64'd1 << 47)) || (mag64 > 64'(COORD_LIMIT))) begin
      mag_c = COORD_LIMIT;
    end else begin
      mag_c = mag64[COORD_W-1:0];
    end
    coord = neg_q ? -$signed(mag_c) : $signed(mag_c);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      if (cmd_i.axis) begin
        y_res_q <= coord;
      end else begin
        x_res_q <= coord;
      end
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      point_x_o         <= x_res_q;
      point_y_o         <= y_res_q;
      point_intensity_o <= inten_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.hit         = sample_intensity_i > thr_q;
  assign sts_o.trig_cached = trig_valid_q && (tag_q == phase_use_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> rtl/polar_radar_to_cartesian_points_core.sv
// Samples at or below the threshold are accepted back to back, with ready held high.
// A sample above the threshold keeps ready low until its point is registered for output,
// after any wait for the previous point. The 28-step CORDIC loop runs unless the row's
// cos/sin pair is cached from the same phase; then the shared multiplier forms four products
// per point (high and low range halves for x, then for y) before the point is emitted.
// Reset: config to defaults, bin counter zero, phase to the angle step, trig cache emptied.
// ----------------------------------------------------------------------------
// polar_radar_to_cartesian_points_core
// Thresholded polar radar samples to Cartesian points.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_radar_to_cartesian_points_core #(
  parameter int MAX_RANGE_BINS = prcp_pkg::MAX_RANGE_BINS_DEF,
  parameter int PHASE_BITS     = prcp_pkg::PHASE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = prcp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [prcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [prcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  prcp_in_if.sink                              in_i,
  prcp_out_if.source                           out_o
);
  import prcp_pkg::*;

  prcp_cmd_t cmd;
  prcp_sts_t sts;
  logic      in_ready;

  prcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prcp_dp #(
    .MAX_RANGE_BINS (MAX_RANGE_BINS),
    .PHASE_BITS     (PHASE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .sample_intensity_i (in_i.sample_intensity),
    .frame_start_i      (in_i.frame_start),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .point_x_o          (out_o.point_x),
    .point_y_o          (out_o.point_y),
    .point_intensity_o  (out_o.point_intensity)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire
